FILE: hw/rtl/v3n_pkg.sv
`timescale 1ns / 1ps

// Shared types and constants for the three-component vector normalizer.
package v3n_pkg;

  // Component format: signed, CW bits, FB of them fractional.
  localparam int CW = 16;
  localparam int FB = 14;

  // Square of one magnitude, and the sum of three squares.
  localparam int SQW = 2 * CW - 1;
  localparam int SW  = 2 * CW;

  // Working width of the remainder recurrence (signed, never overflows).
  localparam int RW = 2 * CW + 2 * FB + 4;

  // Rounded quotient magnitude: 0 .. 2^FB.
  localparam int QW = FB + 1;

  // One result bit per step stage.
  localparam int NSTEP = FB + 1;

  // Width used to saturate the quotient into a component.
  localparam int EW = ((QW > CW) ? QW : CW) + 1;

  // Configuration port.
  localparam int DW = 32;
  localparam int AW = 3;
  localparam logic [AW-3:0] REG_ZERO_THR = '0;
  localparam logic [DW-1:0] THR_RESET = 32'd2684;

  // Width for the threshold compare.
  localparam int CMPW = (SW > DW) ? SW : DW;

  // Cycles from an accepted request to its result strobe.
  localparam int LATENCY = NSTEP + 5;

  // Unit length 1.0 in the component format, one bit wider than a component.
  localparam logic signed [CW:0] ONE_Q = (CW + 1)'(1) << FB;

  typedef struct packed {
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;
  } in_vec_t;

  typedef struct packed {
    logic signed [CW-1:0] x_out;
    logic signed [CW-1:0] y_out;
    logic signed [CW-1:0] z_out;
    logic                 near_zero;
  } out_vec_t;

  // Per-component state of the bit-by-bit quotient search.
  typedef struct packed {
    logic signed [RW-1:0] rem;
    logic signed [RW-1:0] qs;
    logic [QW-1:0]        q;
  } lane_t;

  // Data that rides along unchanged through the search.
  typedef struct packed {
    in_vec_t    raw;
    logic [2:0] neg;
    logic       near_zero;
  } side_t;

  typedef struct packed {
    logic                 valid;
    logic signed [RW-1:0] ss;
    lane_t [2:0]          lane;
    side_t                side;
  } step_t;

endpackage

FILE: hw/rtl/v3n_step.sv
`timescale 1ns / 1ps

// One stage of the rounded quotient search: decides one bit of q for all
// three components. With d = 2q - 1 the stage keeps rem = m^2 * 2^(2FB+2)
// - d^2 * S, qs = d * S scaled to the current bit, and ss = S scaled to the
// current bit, so the trial costs only adds and fixed shifts.
module v3n_step
  import v3n_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  step_t step_i,
  output step_t step_o
);

  step_t                step_nxt;
  step_t                step_r;
  logic signed [RW-1:0] cand   [3];
  logic signed [RW-1:0] qs_acc [3];
  logic                 take   [3];

  // Trial subtraction per component; keep the bit when the remainder stays
  // non-negative.
  always_comb begin
    step_nxt    = step_i;
    step_nxt.ss = step_i.ss >>> 2;
    for (int i = 0; i < 3; i++) begin
      cand[i]   = step_i.lane[i].rem - step_i.lane[i].qs - step_i.ss;
      take[i]   = !cand[i][RW-1];
      qs_acc[i] = take[i] ? (step_i.lane[i].qs + (step_i.ss <<< 1)) : step_i.lane[i].qs;
      step_nxt.lane[i].rem = take[i] ? cand[i] : step_i.lane[i].rem;
      step_nxt.lane[i].qs  = qs_acc[i] >>> 1;
      step_nxt.lane[i].q   = {step_i.lane[i].q[QW-2:0], take[i]};
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    step_r.ss   <= step_nxt.ss;
    step_r.lane <= step_nxt.lane;
    step_r.side <= step_nxt.side;
    if (!rst_n) begin
      step_r.valid <= 1'b0;
    end else begin
      step_r.valid <= step_nxt.valid;
    end
  end

  assign step_o = step_r;

  // A component that has kept any bit has a non-negative remainder.
  a_rem_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    step_o.valid |->
      ((step_o.lane[0].q == '0) || !step_o.lane[0].rem[RW-1]) &&
      ((step_o.lane[1].q == '0) || !step_o.lane[1].rem[RW-1]) &&
      ((step_o.lane[2].q == '0) || !step_o.lane[2].rem[RW-1]))
    else $error("v3n_step: remainder negative after a kept bit");

  // Valid moves one stage per cycle.
  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (step_o.valid == $past(step_i.valid)))
    else $error("v3n_step: valid bit lost or invented");

  // A vector that is normalized has a nonzero squared length in flight.
  a_ss_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (step_o.valid && !step_o.side.near_zero) |-> (step_o.ss != '0))
    else $error("v3n_step: zero length reached the quotient search");

endmodule

FILE: hw/rtl/vector3_normalizer.sv
`timescale 1ns / 1ps

// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+------------------------------
// request  | start, busy, in_data                    | taken when start && !busy
// result   | out_valid, out_data                     | one-cycle strobe, no stall
// config   | psel, penable, pwrite, paddr, pwdata,   | APB write in access phase,
//          | prdata, pready                          | pready always high
//
// A request enters every cycle while busy is low and passes through one input
// stage, one squaring stage, one sum and threshold stage, one setup stage,
// FB + 1 quotient stages (one bit each; FB = 14 with 16-bit components) and
// one output stage. Synchronous active-low reset clears the valid bits and
// loads the threshold register; busy is high while reset is held and in the
// first cycle after it. The receiver cannot stall, so the pipeline never stops.
module vector3_normalizer
  import v3n_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_vec_t       in_data,
  output logic          out_valid,
  output out_vec_t      out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready
);

  logic          busy_r;
  logic [DW-1:0] thr_r;
  logic [DW-1:0] thr_nxt;
  logic          cfg_wr;

  logic          accept;
  logic [CW-1:0] comp_in [3];

  logic          valid1_r;
  in_vec_t       raw1_r;
  logic [2:0]    neg1_r;
  logic [CW-1:0] mag1_r [3];
  logic [2:0]    neg1_nxt;
  logic [CW-1:0] mag1_nxt [3];

  logic            valid2_r;
  in_vec_t         raw2_r;
  logic [2:0]      neg2_r;
  logic [SQW-1:0]  sq2_r [3];
  logic [2*CW-1:0] prod [3];

  logic           valid3_r;
  in_vec_t        raw3_r;
  logic [2:0]     neg3_r;
  logic [SQW-1:0] sq3_r [3];
  logic [SW-1:0]  s3_r;
  logic           near3_r;
  logic [SW-1:0]  s3_nxt;
  logic           near3_nxt;

  step_t init_nxt;
  step_t init_r;
  step_t chain [0:NSTEP];
  step_t fin;

  logic          out_valid_r;
  out_vec_t      out_data_r;
  out_vec_t      out_nxt;
  logic [CW-1:0] enc [3];

  // Saturating sign application of a quotient magnitude.
  function automatic logic [CW-1:0] encode(input logic [QW-1:0] q, input logic neg);
    logic [EW-1:0] qe;
    logic [EW-1:0] lim;
    logic [CW-1:0] mag;
    qe = EW'(q);
    if (neg) begin
      lim = EW'(1) << (CW - 1);
      mag = (qe > lim) ? lim[CW-1:0] : qe[CW-1:0];
      encode = ~mag + CW'(1);
    end else begin
      lim = (EW'(1) << (CW - 1)) - EW'(1);
      encode = (qe > lim) ? lim[CW-1:0] : qe[CW-1:0];
    end
  endfunction

  // Configuration register.
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (paddr[AW-1:2] == REG_ZERO_THR);
  assign thr_nxt = cfg_wr ? pwdata : thr_r;
  assign pready  = 1'b1;
  assign prdata  = (paddr[AW-1:2] == REG_ZERO_THR) ? thr_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      busy_r <= 1'b1;
    end else begin
      thr_r  <= thr_nxt;
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy;

  // Stage 1: component magnitudes and signs.
  assign comp_in[0] = in_data.x_in;
  assign comp_in[1] = in_data.y_in;
  assign comp_in[2] = in_data.z_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg1_nxt[i] = comp_in[i][CW-1];
      mag1_nxt[i] = comp_in[i][CW-1] ? (~comp_in[i] + CW'(1)) : comp_in[i];
    end
  end

  always_ff @(posedge clk) begin
    raw1_r <= in_data;
    neg1_r <= neg1_nxt;
    mag1_r <= mag1_nxt;
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else begin
      valid1_r <= accept;
    end
  end

  // Stage 2: squares of the magnitudes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = (2 * CW)'(mag1_r[i]) * (2 * CW)'(mag1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    raw2_r <= raw1_r;
    neg2_r <= neg1_r;
    for (int i = 0; i < 3; i++) begin
      sq2_r[i] <= prod[i][SQW-1:0];
    end
    if (!rst_n) begin
      valid2_r <= 1'b0;
    end else begin
      valid2_r <= valid1_r;
    end
  end

  // Stage 3: squared length and the near-zero decision.
  assign s3_nxt    = SW'(sq2_r[0]) + SW'(sq2_r[1]) + SW'(sq2_r[2]);
  assign near3_nxt = (CMPW'(s3_nxt) < CMPW'(thr_r)) || (s3_nxt == '0);

  always_ff @(posedge clk) begin
    raw3_r  <= raw2_r;
    neg3_r  <= neg2_r;
    sq3_r   <= sq2_r;
    s3_r    <= s3_nxt;
    near3_r <= near3_nxt;
    if (!rst_n) begin
      valid3_r <= 1'b0;
    end else begin
      valid3_r <= valid2_r;
    end
  end

  // Stage 4: start values of the search with q = 0, i.e. d = -1.
  always_comb begin
    init_nxt.valid          = valid3_r;
    init_nxt.ss             = RW'(s3_r) <<< (2 * FB + 2);
    init_nxt.side.raw       = raw3_r;
    init_nxt.side.neg       = neg3_r;
    init_nxt.side.near_zero = near3_r;
    for (int i = 0; i < 3; i++) begin
      init_nxt.lane[i].rem = (RW'(sq3_r[i]) <<< (2 * FB + 2)) - RW'(s3_r);
      init_nxt.lane[i].qs  = -(RW'(s3_r) <<< (FB + 2));
      init_nxt.lane[i].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    init_r.ss   <= init_nxt.ss;
    init_r.lane <= init_nxt.lane;
    init_r.side <= init_nxt.side;
    if (!rst_n) begin
      init_r.valid <= 1'b0;
    end else begin
      init_r.valid <= init_nxt.valid;
    end
  end

  // Quotient search, one bit per stage, most significant first.
  assign chain[0] = init_r;

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    v3n_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .step_i (chain[j]),
      .step_o (chain[j+1])
    );
  end

  assign fin = chain[NSTEP];

  // Output stage: apply signs, or pass the vector through when near zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      enc[i] = encode(fin.lane[i].q, fin.side.neg[i]);
    end
    if (fin.side.near_zero) begin
      out_nxt.x_out = fin.side.raw.x_in;
      out_nxt.y_out = fin.side.raw.y_in;
      out_nxt.z_out = fin.side.raw.z_in;
    end else begin
      out_nxt.x_out = enc[0];
      out_nxt.y_out = enc[1];
      out_nxt.z_out = enc[2];
    end
    out_nxt.near_zero = fin.side.near_zero;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every accepted request produces its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("vector3_normalizer: result missing after request");

  // No result without a request the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("vector3_normalizer: result without request");

  // A normalized component never exceeds unit length.
  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.near_zero) |->
      ($signed({out_data.x_out[CW-1], out_data.x_out}) <= ONE_Q) &&
      ($signed({out_data.x_out[CW-1], out_data.x_out}) >= -ONE_Q) &&
      ($signed({out_data.y_out[CW-1], out_data.y_out}) <= ONE_Q) &&
      ($signed({out_data.y_out[CW-1], out_data.y_out}) >= -ONE_Q) &&
      ($signed({out_data.z_out[CW-1], out_data.z_out}) <= ONE_Q) &&
      ($signed({out_data.z_out[CW-1], out_data.z_out}) >= -ONE_Q))
    else $error("vector3_normalizer: component beyond unit length");

  // A near-zero vector leaves exactly as it came in.
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.near_zero) |->
      (out_data.x_out == $past(in_data.x_in, LATENCY)) &&
      (out_data.y_out == $past(in_data.y_in, LATENCY)) &&
      (out_data.z_out == $past(in_data.z_in, LATENCY)))
    else $error("vector3_normalizer: near-zero vector altered");

endmodule
